// ===== src/ssr_pkg.sv =====
// ----------------------------------------------------------------------------
// ssr_pkg
// Shared constants and types of the streaming substring replace block.
// ----------------------------------------------------------------------------
package ssr_pkg;

	localparam int MAX_PATTERN     = 8;
	localparam int MAX_REPLACEMENT = 8;
	localparam int WIN_DEPTH       = MAX_PATTERN;
	localparam int BYTE_W          = 8;
	localparam int CNT_W           = $clog2(WIN_DEPTH + 1);
	localparam int REP_CNT_W       = $clog2(MAX_REPLACEMENT + 1);
	localparam int REP_IDX_W       = (MAX_REPLACEMENT > 1) ? $clog2(MAX_REPLACEMENT) : 1;
	localparam int PAT_W           = MAX_PATTERN * BYTE_W;
	localparam int REP_W           = MAX_REPLACEMENT * BYTE_W;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 64;
	localparam int LEN_W           = 4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_BYTES  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LENGTH = 3'd3;

	typedef logic [BYTE_W-1:0] byte_t;

	// control from the sequencer to the row of window cells
	typedef struct packed {
		logic             load;
		logic             shift;
		logic [CNT_W-1:0] count;
	} win_ctl_t;

	// status from the row back to the sequencer
	typedef struct packed {
		byte_t front;
		logic  prefix_ok;
	} win_sts_t;

endpackage

// ===== src/ssr_if.sv =====
// ----------------------------------------------------------------------------
// ssr_in_if / ssr_out_if
// Valid/ready channels for text words in and rewritten words out.
// ----------------------------------------------------------------------------
interface ssr_in_if;
	logic          valid;
	logic          ready;
	ssr_pkg::byte_t text_byte;
	logic          end_of_text;

	modport source (output valid, output text_byte, output end_of_text, input ready);
	modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface ssr_out_if;
	logic          valid;
	logic          ready;
	ssr_pkg::byte_t out_byte;
	logic          byte_valid;
	logic          last_of_run;
	logic          text_done;
	logic          match_seen;

	modport source (output valid, output out_byte, output byte_valid, output last_of_run,
		output text_done, output match_seen, input ready);
	modport sink   (input valid, input out_byte, input byte_valid, input last_of_run,
		input text_done, input match_seen, output ready);
endinterface

// ===== src/stream_substring_replace.sv =====
// ----------------------------------------------------------------------------
// stream_substring_replace
// Streaming search and replace of a short pattern over a byte stream.
// ----------------------------------------------------------------------------
// Text words enter on the text channel (valid/ready), one byte each, with
// end_of_text on the final byte. Rewritten words leave on the rewritten
// channel; every word carries last_of_run on the final word caused by one
// input byte, and text_done plus match_seen on the final word of a text.
// A final byte that leaves nothing to emit yields one bare end marker
// (byte_valid low). Registers are written through cfg_we/cfg_index/cfg_data
// between texts; the user must keep to this, the block does not enforce it.
// One byte is handled at a time. While a byte is in the block, the cell row
// releases or flushes one pending byte per cycle and the replacement is read
// out one byte per cycle into a single-word holding stage, whenever that
// stage is empty or the output register can take its word. The holding
// stage passes each word on to the output register that drives the channel.
// A stalled receiver holds the output register and the holding stage; the
// sequencer waits and text.ready stays low until the run is complete.
// Reset clears the window count, match flag, sequencer and registers to
// pattern length 1, replacement length 0 and zero bytes.
// ----------------------------------------------------------------------------
module stream_substring_replace (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [ssr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ssr_pkg::CFG_DATA_W-1:0] cfg_data,
	ssr_in_if.sink                       text,
	ssr_out_if.source                    rewritten
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_SCAN = 5'b00010,
		ST_REPL = 5'b00100,
		ST_TAIL = 5'b01000,
		ST_FIN  = 5'b10000
	} state_t;

	state_t state_q, state_d;

	logic [ssr_pkg::PAT_W-1:0] pat_bytes_q;
	logic [ssr_pkg::LEN_W-1:0] pat_len_q;
	logic [ssr_pkg::REP_W-1:0] rep_bytes_q;
	logic [ssr_pkg::LEN_W-1:0] rep_len_q;

	logic [ssr_pkg::CNT_W-1:0]     count_q, count_d, plen;
	logic [ssr_pkg::REP_CNT_W-1:0] rlen;
	logic [ssr_pkg::REP_IDX_W-1:0] rep_idx_q, rep_idx_d;
	logic                          any_match_q, eot_q;

	ssr_pkg::byte_t hold_q, push_byte;
	logic           hold_v_q;

	ssr_pkg::byte_t out_byte_q;
	logic           out_v_q, bv_q, last_q, done_q, match_q;

	logic out_free, can_push, push, shift, set_match, fin_fire, accept, full, pre;

	ssr_pkg::win_ctl_t win_ctl;
	ssr_pkg::win_sts_t win_sts;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_bytes_q <= '0;
			pat_len_q   <= ssr_pkg::LEN_W'(1);
			rep_bytes_q <= '0;
			rep_len_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				ssr_pkg::REG_PATTERN_BYTES:      pat_bytes_q <= cfg_data[ssr_pkg::PAT_W-1:0];
				ssr_pkg::REG_PATTERN_LENGTH:     pat_len_q   <= cfg_data[ssr_pkg::LEN_W-1:0];
				ssr_pkg::REG_REPLACEMENT_BYTES:  rep_bytes_q <= cfg_data[ssr_pkg::REP_W-1:0];
				ssr_pkg::REG_REPLACEMENT_LENGTH: rep_len_q   <= cfg_data[ssr_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// effective lengths: empty pattern counts as one byte, both saturate
	always_comb begin
		if (pat_len_q == '0) begin
			plen = ssr_pkg::CNT_W'(1);
		end else if (pat_len_q > ssr_pkg::LEN_W'(ssr_pkg::MAX_PATTERN)) begin
			plen = ssr_pkg::CNT_W'(ssr_pkg::MAX_PATTERN);
		end else begin
			plen = ssr_pkg::CNT_W'(pat_len_q);
		end
		if (rep_len_q > ssr_pkg::LEN_W'(ssr_pkg::MAX_REPLACEMENT)) begin
			rlen = ssr_pkg::REP_CNT_W'(ssr_pkg::MAX_REPLACEMENT);
		end else begin
			rlen = ssr_pkg::REP_CNT_W'(rep_len_q);
		end
	end

	assign accept     = text.valid && text.ready;
	assign text.ready = (state_q == ST_IDLE);

	assign win_ctl.load  = accept;
	assign win_ctl.shift = shift;
	assign win_ctl.count = count_q;

	ssr_window u_window (
		.clk       (clk),
		.ctl       (win_ctl),
		.load_byte (text.text_byte),
		.pattern   (pat_bytes_q),
		.sts       (win_sts)
	);

	assign full     = (count_q == plen) && win_sts.prefix_ok;
	assign pre      = (count_q < plen) && win_sts.prefix_ok;
	assign out_free = !out_v_q || rewritten.ready;
	assign can_push = !hold_v_q || out_free;

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		rep_idx_d = rep_idx_q;
		push      = 1'b0;
		push_byte = win_sts.front;
		shift     = 1'b0;
		set_match = 1'b0;
		fin_fire  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					count_d = count_q + ssr_pkg::CNT_W'(1);
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (full) begin
					set_match = 1'b1;
					count_d   = '0;
					rep_idx_d = '0;
					state_d   = (rlen == '0) ? ST_TAIL : ST_REPL;
				end else if (pre) begin
					state_d = ST_TAIL;
				end else if (can_push) begin
					// release the front byte
					push    = 1'b1;
					shift   = 1'b1;
					count_d = count_q - ssr_pkg::CNT_W'(1);
				end
			end
			ST_REPL: begin
				push_byte = rep_bytes_q[{rep_idx_q, 3'b000} +: ssr_pkg::BYTE_W];
				if (can_push) begin
					push      = 1'b1;
					rep_idx_d = rep_idx_q + ssr_pkg::REP_IDX_W'(1);
					if (ssr_pkg::REP_CNT_W'(rep_idx_q) == rlen - ssr_pkg::REP_CNT_W'(1)) begin
						state_d = ST_TAIL;
					end
				end
			end
			ST_TAIL: begin
				if (eot_q && (count_q != '0)) begin
					// flush the window at end of text
					if (can_push) begin
						push    = 1'b1;
						shift   = 1'b1;
						count_d = count_q - ssr_pkg::CNT_W'(1);
					end
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!(hold_v_q || eot_q)) begin
					state_d = ST_IDLE;
				end else if (out_free) begin
					fin_fire = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rep_idx_q   <= '0;
			any_match_q <= 1'b0;
			eot_q       <= 1'b0;
			hold_v_q    <= 1'b0;
			out_v_q     <= 1'b0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			rep_idx_q <= rep_idx_d;
			if (accept) begin
				eot_q <= text.end_of_text;
			end
			if (set_match) begin
				any_match_q <= 1'b1;
			end else if (fin_fire && eot_q) begin
				any_match_q <= 1'b0;
			end
			if (push) begin
				hold_v_q <= 1'b1;
			end else if (fin_fire) begin
				hold_v_q <= 1'b0;
			end
			if ((push && hold_v_q) || fin_fire) begin
				out_v_q <= 1'b1;
			end else if (rewritten.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// payload of the holding stage and the output register
	always_ff @(posedge clk) begin
		if (push) begin
			hold_q <= push_byte;
		end
		if (push && hold_v_q) begin
			out_byte_q <= hold_q;
			bv_q       <= 1'b1;
			last_q     <= 1'b0;
			done_q     <= 1'b0;
			match_q    <= 1'b0;
		end else if (fin_fire) begin
			// final word of the run, or a bare end marker
			out_byte_q <= hold_v_q ? hold_q : '0;
			bv_q       <= hold_v_q;
			last_q     <= 1'b1;
			done_q     <= eot_q;
			match_q    <= eot_q && any_match_q;
		end
	end

	assign rewritten.valid       = out_v_q;
	assign rewritten.out_byte    = out_byte_q;
	assign rewritten.byte_valid  = bv_q;
	assign rewritten.last_of_run = last_q;
	assign rewritten.text_done   = done_q;
	assign rewritten.match_seen  = match_q;

	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (count_q < ssr_pkg::CNT_W'(ssr_pkg::WIN_DEPTH)))
		else $error("window full while waiting for a byte");

	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !hold_v_q)
		else $error("word left in holding stage after run");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_fire && eot_q) |=> (!any_match_q && (count_q == '0)))
		else $error("state not cleared at end of text");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push && hold_v_q) |-> out_free)
		else $error("held word pushed over a stalled output");

endmodule

// ===== src/ssr_cell.sv =====
// ----------------------------------------------------------------------------
// ssr_cell
// One byte of the pending window: loads, shifts towards the front and
// extends the prefix-match chain with its own comparison.
// ----------------------------------------------------------------------------
module ssr_cell (
	input  logic           clk,
	input  logic           load,
	input  logic           shift,
	input  logic           active,
	input  ssr_pkg::byte_t load_byte,
	input  ssr_pkg::byte_t next_byte,
	input  ssr_pkg::byte_t pat_byte,
	input  logic           ok_in,
	output ssr_pkg::byte_t data,
	output logic           ok_out
);

	ssr_pkg::byte_t data_q;

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_byte;
		end else if (shift) begin
			data_q <= next_byte;
		end
	end

	assign data   = data_q;
	// cells past the fill level do not take part in the compare
	assign ok_out = ok_in & (~active | (data_q == pat_byte));

endmodule

// ===== src/ssr_window.sv =====
// ----------------------------------------------------------------------------
// ssr_window
// Row of window cells; cell 0 is the front of the pending window.
// ----------------------------------------------------------------------------
module ssr_window (
	input  logic                    clk,
	input  ssr_pkg::win_ctl_t       ctl,
	input  ssr_pkg::byte_t          load_byte,
	input  logic [ssr_pkg::PAT_W-1:0] pattern,
	output ssr_pkg::win_sts_t       sts
);

	ssr_pkg::byte_t cell_data [ssr_pkg::WIN_DEPTH];
	logic [ssr_pkg::WIN_DEPTH:0] ok_chain;

	assign ok_chain[0] = 1'b1;

	for (genvar i = 0; i < ssr_pkg::WIN_DEPTH; i++) begin : g_cell
		ssr_pkg::byte_t next_byte;

		if (i == ssr_pkg::WIN_DEPTH - 1) begin : g_tail
			assign next_byte = '0;
		end else begin : g_mid
			assign next_byte = cell_data[i+1];
		end

		ssr_cell u_cell (
			.clk       (clk),
			.load      (ctl.load && (ctl.count == ssr_pkg::CNT_W'(i))),
			.shift     (ctl.shift),
			.active    (ctl.count > ssr_pkg::CNT_W'(i)),
			.load_byte (load_byte),
			.next_byte (next_byte),
			.pat_byte  (pattern[i*ssr_pkg::BYTE_W +: ssr_pkg::BYTE_W]),
			.ok_in     (ok_chain[i]),
			.data      (cell_data[i]),
			.ok_out    (ok_chain[i+1])
		);
	end

	assign sts.front     = cell_data[0];
	assign sts.prefix_ok = ok_chain[ssr_pkg::WIN_DEPTH];

endmodule

// ===== tb/tb_stream_substring_replace.sv =====
// ----------------------------------------------------------------------------
// tb_stream_substring_replace
// Self-checking bench for the streaming substring replace block.
// ----------------------------------------------------------------------------
// A predictor keeps its own pending window, match flag and register copies,
// and works out the rewritten words for every text word the block accepts.
// Each rewritten word is compared field by field with the oldest prediction.
// Stimulus is a short directed part followed by randomised phases. Each
// phase writes a fresh pattern and replacement, some of them outside the
// legal length range, and sends texts built mostly from pattern pieces.
// Both channels idle in random bursts, and the receiver stalls once for a
// long stretch.
// ----------------------------------------------------------------------------
module tb_stream_substring_replace;
	timeunit 1ns;
	timeprecision 1ps;

	import ssr_pkg::*;

	localparam int SETTLE_CYCLES = 16;
	localparam int STALL_LIMIT   = 3000;
	localparam int LONG_HOLD     = 80;
	localparam int RUN_MAX       = 24;
	localparam int N_PHASES      = 12;

	typedef struct packed {
		byte_t ch;
		logic  last;
	} text_word_t;

	typedef struct packed {
		byte_t data;
		logic  is_data;
		logic  run_end;
		logic  text_end;
		logic  hit;
	} rewrite_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	ssr_in_if  text_ch ();
	ssr_out_if rw_ch ();

	stream_substring_replace u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.text      (text_ch),
		.rewritten (rw_ch)
	);

	// predictor copies of the registers and the pending window
	logic [PAT_W-1:0] pat_reg;
	logic [LEN_W-1:0] pat_len_reg;
	logic [REP_W-1:0] rep_reg;
	logic [LEN_W-1:0] rep_len_reg;
	byte_t            pending_win [WIN_DEPTH];
	int unsigned      pending_cnt;
	bit               hit_flag;

	rewrite_t   rewrite_q [$];
	text_word_t text_words [$];
	text_word_t next_word;
	rewrite_t   due_word;
	byte_t      alpha [3];

	int unsigned words_queued, words_taken, words_out, texts_done, texts_hit;
	int unsigned fail_count, idle_run;
	int unsigned send_left, hold_left;
	bit          in_fire, out_fire, quiet, long_hold_req;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int unsigned pat_len_eff();
		if (pat_len_reg == 0) return 1;
		if (pat_len_reg > MAX_PATTERN) return MAX_PATTERN;
		return pat_len_reg;
	endfunction

	function automatic bit prefix_ok(int unsigned n);
		for (int i = 0; i < n; i++)
			if (pending_win[i] != pat_reg[8*i +: 8]) return 1'b0;
		return 1'b1;
	endfunction

	function automatic rewrite_t plain(byte_t b);
		return '{b, 1'b1, 1'b0, 1'b0, 1'b0};
	endfunction

	// work out the rewritten words caused by one text word
	function automatic void rewrite_word(byte_t ch, logic last);
		rewrite_t    run [RUN_MAX];
		int          n;
		int unsigned plen;
		int unsigned rlen;
		n = 0;
		plen = pat_len_eff();
		rlen = (rep_len_reg > MAX_REPLACEMENT) ? MAX_REPLACEMENT : rep_len_reg;
		pending_win[pending_cnt] = ch;
		pending_cnt++;
		forever begin
			if (pending_cnt == plen && prefix_ok(plen)) begin
				for (int i = 0; i < rlen; i++) begin
					run[n] = plain(rep_reg[8*i +: 8]);
					n++;
				end
				pending_cnt = 0;
				hit_flag = 1'b1;
				break;
			end
			if (pending_cnt < plen && prefix_ok(pending_cnt)) break;
			// release the front byte
			run[n] = plain(pending_win[0]);
			n++;
			for (int i = 0; i < WIN_DEPTH - 1; i++) pending_win[i] = pending_win[i+1];
			pending_win[WIN_DEPTH-1] = '0;
			pending_cnt--;
		end
		if (last) begin
			for (int i = 0; i < pending_cnt; i++) begin
				run[n] = plain(pending_win[i]);
				n++;
			end
			if (n == 0) begin
				run[0] = '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0};
				n = 1;
			end
			run[n-1].text_end = 1'b1;
			run[n-1].hit = hit_flag;
			foreach (pending_win[i]) pending_win[i] = '0;
			pending_cnt = 0;
			hit_flag = 1'b0;
		end
		if (n > 0) run[n-1].run_end = 1'b1;
		for (int i = 0; i < n; i++) rewrite_q.push_back(run[i]);
	endfunction

	function automatic void check_field(string name, logic [7:0] expv, logic [7:0] act);
		if (act !== expv) begin
			$error("%s: expected %0h, got %0h", name, expv, act);
			fail_count++;
		end
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_PATTERN_BYTES:      pat_reg = val;
			REG_PATTERN_LENGTH:     pat_len_reg = val[LEN_W-1:0];
			REG_REPLACEMENT_BYTES:  rep_reg = val;
			REG_REPLACEMENT_LENGTH: rep_len_reg = val[LEN_W-1:0];
			default: ;
		endcase
	endtask

	task automatic configure(logic [CFG_DATA_W-1:0] pat, logic [CFG_DATA_W-1:0] plen,
		logic [CFG_DATA_W-1:0] rep, logic [CFG_DATA_W-1:0] rlen);
		write_reg(REG_PATTERN_BYTES, pat);
		write_reg(REG_PATTERN_LENGTH, plen);
		write_reg(REG_REPLACEMENT_BYTES, rep);
		write_reg(REG_REPLACEMENT_LENGTH, rlen);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic add_word(byte_t ch, logic last);
		text_words.push_back('{ch, last});
		words_queued++;
	endtask

	// wait for every word to be taken and every prediction to be met
	task automatic drain();
		while (words_taken != words_queued || rewrite_q.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// text built from whole and partial occurrences, alphabet bytes and noise
	task automatic gen_text(int unsigned count, bit close);
		byte_t       part [$];
		int unsigned plen;
		int unsigned k;
		plen = pat_len_eff();
		while (part.size() < count) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: for (int i = 0; i < plen; i++) part.push_back(pat_reg[8*i +: 8]);
				4, 5: begin
					k = $urandom_range(1, plen);
					for (int i = 0; i < k; i++) part.push_back(pat_reg[8*i +: 8]);
				end
				6, 7, 8: part.push_back(alpha[$urandom_range(0, 2)]);
				default: part.push_back(byte_t'($urandom));
			endcase
		end
		foreach (part[i])
			add_word(part[i], (i == part.size() - 1) ? close : ($urandom_range(0, 11) == 0));
	endtask

	task automatic random_phase(int unsigned count, bit close, bit stall);
		logic [CFG_DATA_W-1:0] pat, rep, plen_d, rlen_d;
		foreach (alpha[i]) alpha[i] = byte_t'($urandom);
		for (int i = 0; i < MAX_PATTERN; i++) pat[8*i +: 8] = alpha[$urandom_range(0, 2)];
		rep = {$urandom, $urandom};
		plen_d = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : '0;
		rlen_d = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : '0;
		case ($urandom_range(0, 9))
			0:       plen_d[LEN_W-1:0] = '0;
			1:       plen_d[LEN_W-1:0] = LEN_W'($urandom_range(9, 15));
			2:       plen_d[LEN_W-1:0] = LEN_W'(MAX_PATTERN);
			default: plen_d[LEN_W-1:0] = LEN_W'($urandom_range(1, 8));
		endcase
		case ($urandom_range(0, 9))
			0:       rlen_d[LEN_W-1:0] = '0;
			1:       rlen_d[LEN_W-1:0] = LEN_W'($urandom_range(9, 15));
			2:       rlen_d[LEN_W-1:0] = LEN_W'(MAX_REPLACEMENT);
			default: rlen_d[LEN_W-1:0] = LEN_W'($urandom_range(0, 8));
		endcase
		configure(pat, plen_d, rep, rlen_d);
		gen_text(count, close);
		if (stall) long_hold_req = 1'b1;
		drain();
	endtask

	// text driver
	always @(negedge clk) begin
		if (!arst_n) begin
			text_ch.valid <= 1'b0;
		end else if (!text_ch.valid || in_fire) begin
			if (send_left != 0) begin
				send_left--;
				text_ch.valid <= 1'b0;
			end else if (text_words.size() == 0) begin
				text_ch.valid <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				send_left = $urandom_range(0, 13);
				text_ch.valid <= 1'b0;
			end else begin
				next_word = text_words.pop_front();
				text_ch.valid       <= 1'b1;
				text_ch.text_byte   <= next_word.ch;
				text_ch.end_of_text <= next_word.last;
			end
		end
	end

	// receiver back-pressure
	always @(negedge clk) begin
		if (!arst_n) begin
			rw_ch.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
			rw_ch.ready <= 1'b0;
		end else if (long_hold_req) begin
			long_hold_req = 1'b0;
			hold_left = LONG_HOLD - 1;
			rw_ch.ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			hold_left = $urandom_range(0, 13);
			rw_ch.ready <= 1'b0;
		end else begin
			rw_ch.ready <= 1'b1;
		end
	end

	// predict on every accepted text word, check every rewritten word
	always @(posedge clk) begin
		if (arst_n) begin
			in_fire  = text_ch.valid && text_ch.ready;
			out_fire = rw_ch.valid && rw_ch.ready;
			if (in_fire) begin
				rewrite_word(text_ch.text_byte, text_ch.end_of_text);
				words_taken++;
			end
			if (out_fire) begin
				words_out++;
				if (rewrite_q.size() == 0) begin
					$error("rewritten word %0h arrived with none expected", rw_ch.out_byte);
					fail_count++;
				end else begin
					due_word = rewrite_q.pop_front();
					check_field("out_byte", due_word.data, rw_ch.out_byte);
					check_field("byte_valid", 8'(due_word.is_data), 8'(rw_ch.byte_valid));
					check_field("last_of_run", 8'(due_word.run_end), 8'(rw_ch.last_of_run));
					check_field("text_done", 8'(due_word.text_end), 8'(rw_ch.text_done));
					check_field("match_seen", 8'(due_word.hit), 8'(rw_ch.match_seen));
					if (due_word.text_end) begin
						texts_done++;
						if (due_word.hit) texts_hit++;
					end
				end
			end
			idle_run = (in_fire || out_fire) ? 0 : idle_run + 1;
		end
	end

	initial begin
		@(posedge arst_n);
		while (idle_run < STALL_LIMIT) @(posedge clk);
		$display("No word moved for %0d cycles, %0d rewritten words outstanding",
			idle_run, rewrite_q.size());
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		text_ch.valid       = 1'b0;
		text_ch.text_byte   = '0;
		text_ch.end_of_text = 1'b0;
		rw_ch.ready         = 1'b0;
		cfg_we              = 1'b0;
		cfg_index           = '0;
		cfg_data            = '0;
		quiet               = 1'b0;
		long_hold_req       = 1'b0;
		pat_reg             = '0;
		pat_len_reg         = LEN_W'(1);
		rep_reg             = '0;
		rep_len_reg         = '0;
		foreach (pending_win[i]) pending_win[i] = '0;
		pending_cnt         = 0;
		hit_flag            = 1'b0;
		arst_n              = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset registers: zero byte deleted, final word leaves a bare end marker
		@(posedge clk);
		add_word(8'h00, 1'b0);
		add_word(8'h41, 1'b0);
		add_word(8'h00, 1'b1);
		drain();

		// "abc" -> "XY" on "aabcab", tail flushed at the end
		configure(64'h636261, 64'd3, 64'h5958, 64'd2);
		add_word(8'h61, 1'b0);
		add_word(8'h61, 1'b0);
		add_word(8'h62, 1'b0);
		add_word(8'h63, 1'b0);
		add_word(8'h61, 1'b0);
		add_word(8'h62, 1'b1);
		drain();

		// zero pattern length acts as one, oversized replacement length saturates
		configure(64'h71, {{60{1'b1}}, 4'd0}, '1, 64'd15);
		add_word(8'h71, 1'b0);
		add_word(8'h72, 1'b1);
		drain();

		// full-length all-ones pattern deleted, then leave a window pending
		configure('1, 64'd8, '0, 64'd0);
		repeat (11) add_word(8'hFF, 1'b0);
		drain();

		// shrink the pattern with the window still pending
		configure(64'hFFFF, 64'd2, 64'h5A, 64'd1);
		add_word(8'h00, 1'b1);
		drain();

		for (int p = 0; p < N_PHASES; p++) begin
			quiet = (p >= N_PHASES - 2);
			random_phase($urandom_range(10, 20), (p == N_PHASES - 1) || ($urandom_range(0, 3) != 0),
				p == 2);
		end

		$display("Run covered %0d text words and %0d rewritten words over %0d texts",
			words_taken, words_out, texts_done);
		$display("(%0d texts with a replacement), across %0d register settings",
			texts_hit, N_PHASES + 4);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
